### sv/vpa_pkg.sv
// Shared types and constants of the voice pool allocator.
// No dependencies; every other file but vpa_ram imports this package.
`default_nettype none

package vpa_pkg;

    // Pool size and derived widths
    localparam int VOICES = 64;
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;   // voice index
    localparam int CW     = $clog2(VOICES + 1);                  // counts 0..VOICES

    // Fixed field widths
    localparam int NOTE_W   = 7;
    localparam int VOICE_FW = 6;
    localparam int COUNT_FW = 7;

    // Opcodes
    localparam logic OP_NOTE_ON  = 1'b0;
    localparam logic OP_NOTE_OFF = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [NOTE_W-1:0] note_number;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [VOICE_FW-1:0] voice_number;
        logic [COUNT_FW-1:0] freed_count;
        logic [COUNT_FW-1:0] busy_count;
    } rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_in;     // latch request beat, clear scan state
        logic rd_idle;     // read top of idle stack
        logic do_alloc;    // hand out the voice read from the stack
        logic rd_active;   // read active list at scan index
        logic rd_note;     // latch voice, read its note
        logic do_sort;     // keep or free the scanned voice
        logic commit_off;  // active depth takes the kept count
        logic load_out;    // load result register
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic op_off;
        logic pool_empty;
        logic active_empty;
        logic scan_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### sv/voice_pool_allocator_unit.sv
// Top level of the voice pool allocator: sequencer plus datapath.
// Depends on vpa_pkg, vpa_ctrl, vpa_dp (and through it vpa_ram).
//
//  channel  | handshake             | payload        | dir
//  ---------+-----------------------+----------------+-----
//  request  | req_valid / req_ready | req (req_t)    | in
//  result   | rsp_valid / rsp_ready | rsp (rsp_t)    | out
//
// One result beat per request beat, in order.
// Note-on: reads the top of the idle stack and hands out that voice; skipped
// if the pool is empty. Note-off: walks the active list, per active voice a
// list read, a note read and a keep/free write; skipped on an empty list.
// rst_n is asynchronous; the pool comes up with every voice idle, voice
// VOICES-1 on top of the stack. No clearing pass is needed.
// A request beat may be taken while the previous result still waits;
// that item then holds in its last step until the result register frees.
`default_nettype none

module voice_pool_allocator_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire vpa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output vpa_pkg::rsp_t      rsp
);
    import vpa_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Step sequencing and both handshakes
    vpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Pool memories, counters and result register
    vpa_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

### sv/vpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/vpa_ctrl.sv
// Sequencer of the voice pool allocator: handshakes and step order.
// Depends on vpa_pkg.
`default_nettype none

module vpa_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    input  wire vpa_pkg::dp_stat_t  stat,
    output vpa_pkg::ctl_cmd_t       cmd
);
    import vpa_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_ON_RD    = 3'd2;
    localparam logic [2:0] S_ON_WR    = 3'd3;
    localparam logic [2:0] S_OFF_RD   = 3'd4;
    localparam logic [2:0] S_OFF_NOTE = 3'd5;
    localparam logic [2:0] S_OFF_WR   = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       commit_pend_reg, commit_pend_next;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next       = state_reg;
        commit_pend_next = commit_pend_reg;
        cmd              = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (stat.op_off)
                begin
                    state_next = stat.active_empty ? S_DONE : S_OFF_RD;
                end
                else
                begin
                    state_next = stat.pool_empty ? S_DONE : S_ON_RD;
                end
            end
            S_ON_RD:
            begin
                cmd.rd_idle = 1'b1;
                state_next  = S_ON_WR;
            end
            S_ON_WR:
            begin
                cmd.do_alloc = 1'b1;
                state_next   = S_DONE;
            end
            S_OFF_RD:
            begin
                cmd.rd_active = 1'b1;
                state_next    = S_OFF_NOTE;
            end
            S_OFF_NOTE:
            begin
                cmd.rd_note = 1'b1;
                state_next  = S_OFF_WR;
            end
            S_OFF_WR:
            begin
                cmd.do_sort = 1'b1;
                if (stat.scan_last)
                begin
                    commit_pend_next = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_OFF_RD;
                end
            end
            S_DONE:
            begin
                // Active depth takes the kept count before the result loads.
                if (commit_pend_reg)
                begin
                    cmd.commit_off   = 1'b1;
                    commit_pend_next = 1'b0;
                end
                else if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rsp_valid_reg   <= 1'b0;
            commit_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rsp_valid_reg   <= rsp_valid_next;
            commit_pend_reg <= commit_pend_next;
        end
    end

endmodule

`default_nettype wire

### sv/vpa_dp.sv
// Datapath: idle stack, active list and note memories, depth counters,
// scan pointers and the result register. Depends on vpa_pkg, vpa_ram.
`default_nettype none

module vpa_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire vpa_pkg::req_t      req,
    input  wire vpa_pkg::ctl_cmd_t  cmd,
    output vpa_pkg::dp_stat_t       stat,
    output vpa_pkg::rsp_t           rsp
);
    import vpa_pkg::*;

    logic [CW-1:0]     idle_depth_reg, active_depth_reg;
    logic [CW-1:0]     idx_reg, kept_reg, freed_reg;
    logic              op_reg, granted_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VW-1:0]     voice_reg;
    logic [VOICES-1:0] idle_vld_reg;     // stack entry written since reset
    logic              idle_hit_reg;
    logic [VW-1:0]     idle_raddr_reg;
    rsp_t              rsp_reg;

    logic              match;
    logic [VW-1:0]     top_voice;

    logic              act_we;
    logic [VW-1:0]     act_waddr, act_wdata, act_rdata;
    logic              idle_we;
    logic [VW-1:0]     idle_waddr, idle_raddr, idle_rdata;
    logic [NOTE_W-1:0] note_rdata;

    // Unwritten stack entry reads as its reset value: its own index.
    assign top_voice = idle_hit_reg ? idle_rdata : idle_raddr_reg;
    assign match     = (note_rdata == note_reg);

    assign idle_raddr = VW'(idle_depth_reg - CW'(1));
    assign idle_we    = cmd.do_sort && match;
    assign idle_waddr = VW'(idle_depth_reg);

    assign act_we    = cmd.do_alloc || (cmd.do_sort && !match);
    assign act_waddr = cmd.do_alloc ? VW'(active_depth_reg) : VW'(kept_reg);
    assign act_wdata = cmd.do_alloc ? top_voice : voice_reg;

    vpa_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_idle_ram (
        .clk   (clk),
        .we    (idle_we),
        .waddr (idle_waddr),
        .wdata (voice_reg),
        .re    (cmd.rd_idle),
        .raddr (idle_raddr),
        .rdata (idle_rdata)
    );

    vpa_ram #(.WIDTH(VW), .DEPTH(VOICES)) u_active_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (cmd.rd_active),
        .raddr (VW'(idx_reg)),
        .rdata (act_rdata)
    );

    vpa_ram #(.WIDTH(NOTE_W), .DEPTH(VOICES)) u_note_ram (
        .clk   (clk),
        .we    (cmd.do_alloc),
        .waddr (top_voice),
        .wdata (note_reg),
        .re    (cmd.rd_note),
        .raddr (act_rdata),
        .rdata (note_rdata)
    );

    assign stat.op_off       = (op_reg == OP_NOTE_OFF);
    assign stat.pool_empty   = (idle_depth_reg == '0);
    assign stat.active_empty = (active_depth_reg == '0);
    assign stat.scan_last    = ((idx_reg + CW'(1)) == active_depth_reg);

    assign rsp = rsp_reg;

    // Control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_depth_reg   <= CW'(VOICES);
            active_depth_reg <= '0;
            idle_vld_reg     <= '0;
        end
        else
        begin
            if (cmd.do_alloc)
            begin
                idle_depth_reg   <= idle_depth_reg - CW'(1);
                active_depth_reg <= active_depth_reg + CW'(1);
            end
            if (idle_we)
            begin
                idle_depth_reg           <= idle_depth_reg + CW'(1);
                idle_vld_reg[idle_waddr] <= 1'b1;
            end
            if (cmd.commit_off)
            begin
                active_depth_reg <= kept_reg;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= req.opcode;
            note_reg    <= req.note_number;
            idx_reg     <= '0;
            kept_reg    <= '0;
            freed_reg   <= '0;
            granted_reg <= 1'b0;
        end
        if (cmd.rd_idle)
        begin
            idle_hit_reg   <= idle_vld_reg[idle_raddr];
            idle_raddr_reg <= idle_raddr;
        end
        if (cmd.do_alloc)
        begin
            voice_reg   <= top_voice;
            granted_reg <= 1'b1;
        end
        if (cmd.rd_note)
        begin
            voice_reg <= act_rdata;
        end
        if (cmd.do_sort)
        begin
            idx_reg <= idx_reg + CW'(1);
            if (match)
            begin
                freed_reg <= freed_reg + CW'(1);
            end
            else
            begin
                kept_reg <= kept_reg + CW'(1);
            end
        end
        if (cmd.load_out)
        begin
            rsp_reg.granted      <= granted_reg;
            rsp_reg.voice_number <= granted_reg ? VOICE_FW'(voice_reg) : '0;
            rsp_reg.freed_count  <= COUNT_FW'(freed_reg);
            rsp_reg.busy_count   <= COUNT_FW'(active_depth_reg);
        end
    end

endmodule

`default_nettype wire

### sv/vpa_checker.sv
// Port-level checks of the voice pool allocator, bound to the top level.
// Depends on vpa_pkg and voice_pool_allocator_unit.
`default_nettype none

module vpa_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          req_valid,
    input wire logic          req_ready,
    input wire logic          rsp_valid,
    input wire logic          rsp_ready,
    input wire vpa_pkg::rsp_t rsp
);
    import vpa_pkg::*;

    logic [1:0] pend_reg;   // items accepted, result not yet taken
    logic       req_acc, rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (req_acc && !rsp_acc)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (rsp_acc && !req_acc)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat dropped or changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("result beat without a request");

    a_one_deep: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == 2'd2 |-> !req_ready)
        else $error("request taken with two items outstanding");

    a_grant_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.granted |-> rsp.freed_count == '0 && rsp.busy_count != '0)
        else $error("grant with freed voices or empty pool");

    a_busy_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.granted |-> rsp.voice_number == '0
            && rsp.busy_count <= COUNT_FW'(VOICES))
        else $error("bad voice number or busy count");

endmodule

bind voice_pool_allocator_unit vpa_checker u_vpa_checker (.*);

`default_nettype wire
